// ----- hw/rtl/bvle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bvle_pkg;

  localparam int unsigned ListDepthDef = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned PosW         = 5;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_SEARCH = 3'd3,
    KIND_MAX    = 3'd4,
    KIND_MIN    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_e;

  // the operation that every cell of the chain performs
  typedef enum logic [1:0] {
    CELL_KEEP,    // hold the stored value
    CELL_PUSH,    // take the left neighbor, head takes the new value
    CELL_ROTATE,  // take the right neighbor, tail takes the head
    CELL_DROP     // take the right neighbor, head is discarded
  } cell_op_e;

endpackage

`default_nettype wire

// ----- hw/rtl/bvle_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bvle_cell
  import bvle_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDef,
  parameter int unsigned Index     = 0,
  localparam int unsigned CntW     = $clog2(ListDepth + 1)
) (
  input  wire                      clk_i,
  input  cell_op_e                 op_i,
  input  wire  [CntW-1:0]          count_i,
  input  wire  signed [ValueW-1:0] left_i,
  input  wire  signed [ValueW-1:0] right_i,
  input  wire  signed [ValueW-1:0] head_i,
  output logic signed [ValueW-1:0] value_o
);

  localparam logic [CntW-1:0] TailCount = CntW'(Index + 1);

  logic signed [ValueW-1:0] value_d, value_q;
  logic                     is_tail;

  // this cell holds the last valid entry
  assign is_tail = (count_i == TailCount);

  always_comb begin
    value_d = value_q;
    case (op_i)
      CELL_PUSH:   value_d = left_i;
      CELL_ROTATE: value_d = is_tail ? head_i : right_i;
      CELL_DROP:   value_d = right_i;
      default:     value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_value_list_engine.sv -----
// flow: insert, clear, unused kinds and any item on an empty list go straight to ST_HOLD;
//   search, remove, maximum and minimum first rotate each entry past the head in ST_WALK,
//   one per cycle; ST_HOLD raises output valid once the output register is free
// throughput: one item at a time, a new transaction is taken once the previous item has
//   reached the output register (which may still be waiting for the consumer)
// reset: rst_ni asynchronous active low empties the list and drops any pending result
`timescale 1ns / 1ps
`default_nettype none

module bounded_value_list_engine
  import bvle_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDef
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire  [KindW-1:0]         kind_i,
  input  wire  signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output logic signed [ValueW-1:0] result_value_o,
  output logic [PosW-1:0]          position_o,
  output logic                     found_o,
  output logic                     empty_res_o,
  output logic                     full_res_o
);

  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(ListDepth);

  // control state
  state_e            state_d, state_q;
  logic [CntW-1:0]   count_d, count_q;   // valid entries, head at cell 0
  logic [CntW-1:0]   steps_d, steps_q;   // walk length, entry count when the walk started
  logic [CntW-1:0]   step_d, step_q;     // entries already past the head
  logic              out_valid_d, out_valid_q;

  // item and staged result
  kind_e                    kind_d, kind_q;
  logic signed [ValueW-1:0] key_d, key_q;
  logic signed [ValueW-1:0] res_val_d, res_val_q;
  logic [PosW-1:0]          pos_d, pos_q;
  logic                     found_d, found_q;
  logic                     empty_d, empty_q;
  logic                     full_d, full_q;

  // output register
  logic signed [ValueW-1:0] out_val_d, out_val_q;
  logic [PosW-1:0]          out_pos_d, out_pos_q;
  logic                     out_found_d, out_found_q;
  logic                     out_empty_d, out_empty_q;
  logic                     out_full_d, out_full_q;

  // cell chain
  cell_op_e                 cell_op;
  logic signed [ValueW-1:0] cell_val [ListDepth];
  logic signed [ValueW-1:0] head;
  logic                     match;
  logic [CntW-1:0]          step_inc;
  logic [CntW+PosW-1:0]     pos_ext;

  assign head     = cell_val[0];
  assign step_inc = step_q + CntW'(1);
  // 1-based position, low bits only when the list is deeper than the field
  assign pos_ext  = {{PosW{1'b0}}, step_inc};
  assign match    = !found_q && (head == key_q);

  genvar gi;
  generate
    for (gi = 0; gi < ListDepth; gi++) begin : g_cell
      logic signed [ValueW-1:0] left_val;
      logic signed [ValueW-1:0] right_val;

      // the head takes the new value on a push
      if (gi == 0) begin : g_head
        assign left_val = value_i;
      end else begin : g_body
        assign left_val = cell_val[gi-1];
      end

      // the last cell only ever wraps back to the head
      if (gi == ListDepth - 1) begin : g_last
        assign right_val = cell_val[0];
      end else begin : g_inner
        assign right_val = cell_val[gi+1];
      end

      bvle_cell #(
        .ListDepth (ListDepth),
        .Index     (gi)
      ) u_cell (
        .clk_i   (clk_i),
        .op_i    (cell_op),
        .count_i (count_q),
        .left_i  (left_val),
        .right_i (right_val),
        .head_i  (head),
        .value_o (cell_val[gi])
      );
    end
  endgenerate

  // next state, chain control, result staging and output register
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    steps_d   = steps_q;
    step_d    = step_q;
    kind_d    = kind_q;
    key_d     = key_q;
    res_val_d = res_val_q;
    pos_d     = pos_q;
    found_d   = found_q;
    empty_d   = empty_q;
    full_d    = full_q;
    cell_op   = CELL_KEEP;
    in_ready_o = 1'b0;

    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d    = kind_e'(kind_i);
          key_d     = value_i;
          res_val_d = '0;
          pos_d     = '0;
          found_d   = 1'b0;
          full_d    = 1'b0;
          empty_d   = (count_q == '0);
          steps_d   = count_q;
          step_d    = '0;
          state_d   = ST_HOLD;
          case (kind_e'(kind_i))
            KIND_INSERT: begin
              if (count_q == FullCount) begin
                full_d = 1'b1;
              end else begin
                cell_op = CELL_PUSH;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_REMOVE, KIND_SEARCH, KIND_MAX, KIND_MIN: begin
              if (count_q != '0) begin
                state_d = ST_WALK;
              end
            end
            default: begin
              state_d = ST_HOLD;
            end
          endcase
        end
      end

      ST_WALK: begin
        // one entry passes the head per cycle
        cell_op = CELL_ROTATE;
        case (kind_q)
          KIND_SEARCH: begin
            if (match) begin
              found_d   = 1'b1;
              pos_d     = pos_ext[PosW-1:0];
              res_val_d = head;
            end
          end
          KIND_REMOVE: begin
            if (match) begin
              found_d   = 1'b1;
              pos_d     = pos_ext[PosW-1:0];
              res_val_d = head;
              cell_op   = CELL_DROP;
              count_d   = count_q - CntW'(1);
            end
          end
          KIND_MAX: begin
            if (step_q == '0 || head > res_val_q) begin
              res_val_d = head;
            end
          end
          KIND_MIN: begin
            if (step_q == '0 || head < res_val_q) begin
              res_val_d = head;
            end
          end
          default: begin
            cell_op = CELL_KEEP;
          end
        endcase
        step_d = step_inc;
        if (step_inc == steps_q) begin
          state_d = ST_HOLD;
        end
      end

      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_pos_d   = pos_q;
          out_found_d = found_q;
          out_empty_d = empty_q;
          out_full_d  = full_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      steps_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      steps_q     <= steps_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    key_q       <= key_d;
    res_val_q   <= res_val_d;
    pos_q       <= pos_d;
    found_q     <= found_d;
    empty_q     <= empty_d;
    full_q      <= full_d;
    out_val_q   <= out_val_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign position_o     = out_pos_q;
  assign found_o        = out_found_q;
  assign empty_res_o    = out_empty_q;
  assign full_res_o     = out_full_q;

`ifndef ASSERT_OFF
  // the entry count never passes the list depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count above list depth");

  // a walk never runs past the entries it started with
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> (step_q < steps_q))
    else $error("walk step beyond start count");

  // a remove drops exactly one entry
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && cell_op == CELL_DROP) |=> count_q == $past(count_q) - CntW'(1))
    else $error("remove did not shrink the list by one");

  // only search and remove report a match
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && found_q) |-> (kind_q == KIND_SEARCH || kind_q == KIND_REMOVE))
    else $error("match flagged for a kind without lookup");
`endif

endmodule

`default_nettype wire
